[src/htw_pkg.sv]
// package for the hierarchical timer wheel: sizes, codes, sequencer states
// and the result id helper; no dependencies
package htw_pkg;

    localparam int L1_BITS   = 8;
    localparam int LV_BITS   = 6;
    localparam int POOL_SIZE = 32;
    localparam int L1_SLOTS  = 1 << L1_BITS;
    localparam int LV_SLOTS  = 1 << LV_BITS;
    localparam int NUM_SLOTS = L1_SLOTS + 4 * LV_SLOTS;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    localparam int ID_W      = $clog2(POOL_SIZE);
    localparam int LINK_W    = $clog2(POOL_SIZE + 1);

    localparam logic [1:0] FN_ARM    = 2'd0;
    localparam logic [1:0] FN_TICK   = 2'd1;
    localparam logic [1:0] FN_CANCEL = 2'd2;

    localparam logic [1:0] MODE_FOREVER = 2'd1;
    localparam logic [1:0] MODE_COUNTED = 2'd2;
    localparam logic [1:0] MODE_BAD     = 2'd3;

    localparam logic [2:0] ST_ARMED     = 3'd0;
    localparam logic [2:0] ST_BAD_TO    = 3'd1;
    localparam logic [2:0] ST_BAD_MODE  = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_EXPIRED   = 3'd4;
    localparam logic [2:0] ST_DONE      = 3'd5;
    localparam logic [2:0] ST_CANCELLED = 3'd6;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_TICK, S_CAS_RD, S_CAS_CLR, S_CAS_NEXT,
        S_FI_RD, S_FI_CLR, S_FI_NEXT, S_FI_UPD,
        S_PL_RD, S_PL_APPLY, S_PL_LINK,
        S_UN_RD, S_UN_AP, S_UN_P, S_UN_N, S_EMIT
    } t_state;

    function automatic logic [4:0] f_rid(input logic [ID_W-1:0] id);
        logic [ID_W+4:0] tmp;
        tmp = {5'b0, id};
        return tmp[4:0];
    endfunction

endpackage

[src/hierarchical_timer_wheel.sv]
// top level of the five-level timer wheel: sequencer, timer pool registers
// uses htw_pkg, htw_slot_ram and htw_place
//
//  channel | direction | handshake                 | payload
//  in      | input     | i_in_valid / o_in_stall   | func, timeout_ms, repeat_mode,
//          |           |                           | repeat_count, timer_id
//  out     | output    | o_out_valid / i_out_stall | status, result_timer, last
//
// after reset a clearing pass writes every slot (NUM_SLOTS, 512), stall held
// arm, cancel and tick run through the sequencer states; a tick cascades the due
// level slots, moving their timers, then fires the level-1 slot and re-arms timers
// that repeat, paced by the one slot memory port and the one timer pool index per cycle
// one item at a time; a result beat waits in the output register while the next
// item is taken, and a new beat holds the sequencer only while the register is stalled
module hierarchical_timer_wheel (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_func,
    input  logic [31:0] i_timeout_ms,
    input  logic [1:0]  i_repeat_mode,
    input  logic [31:0] i_repeat_count,
    input  logic [4:0]  i_timer_id,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [4:0]  o_result_timer,
    output logic        o_last
);
    import htw_pkg::*;

    t_state r_state, n_state, r_ret, n_ret, r_after, n_after;
    logic [SLOT_W-1:0] r_clr, n_clr, r_pslot, n_pslot;
    logic [1:0]        r_k, n_k;
    logic [LINK_W-1:0] r_h, n_h, r_t, n_t, r_p, n_p, r_n, n_n;
    logic [ID_W-1:0]   r_id, n_id;
    logic [31:0]       r_tick, n_tick;
    logic [2:0]        r_est, n_est;
    logic [4:0]        r_eid, n_eid;
    logic              r_elast, n_elast;
    logic              r_ov;
    logic [2:0]        r_ost;
    logic [4:0]        r_oid;
    logic              r_olast;

    logic [31:0]       r_expiry   [POOL_SIZE];
    logic [31:0]       r_interval [POOL_SIZE];
    logic [31:0]       r_remain   [POOL_SIZE];
    logic [1:0]        r_mode     [POOL_SIZE];
    logic [LINK_W-1:0] r_prev     [POOL_SIZE];
    logic [LINK_W-1:0] r_next     [POOL_SIZE];
    logic [SLOT_W-1:0] r_where    [POOL_SIZE];
    logic [POOL_SIZE-1:0] r_used;

    logic [ID_W-1:0]   tidx;
    logic              arm_we, exp_we, rem_we, prev_we, next_we, where_we;
    logic              used_clr;
    logic [31:0]       exp_val, rem_val;
    logic [LINK_W-1:0] prev_val, next_val;

    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr, ram_raddr;
    logic [2*LINK_W-1:0] ram_wdata, ram_rdata;
    logic [LINK_W-1:0] rd_head, rd_tail;

    logic [SLOT_W-1:0] pl_slot, cslot, fslot;
    logic [63:0]       tk64;
    logic [LV_BITS-1:0] dig;
    logic              free_any;
    logic [ID_W-1:0]   free_id;
    logic              out_free, emit_go, again;
    logic [31:0]       rem_m1;
    logic [LINK_W-1:0] id_p1;
    logic [5:0]        tid6;

    assign rd_head = ram_rdata[2*LINK_W-1:LINK_W];
    assign rd_tail = ram_rdata[LINK_W-1:0];

    htw_slot_ram #(
        .DEPTH (NUM_SLOTS),
        .AW    (SLOT_W),
        .DW    (2 * LINK_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    htw_place u_place (
        .i_expiry (r_expiry[tidx]),
        .i_tick   (r_tick),
        .o_slot   (pl_slot)
    );

    // lowest free timer
    always_comb begin
        free_any = 1'b0;
        free_id  = '0;
        for (int i = POOL_SIZE - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_any = 1'b1;
                free_id  = ID_W'(i);
            end
        end
    end

    assign tk64 = {32'b0, r_tick};
    always_comb begin
        unique case (r_k)
            2'd0: dig = tk64[L1_BITS +: LV_BITS];
            2'd1: dig = tk64[L1_BITS + LV_BITS +: LV_BITS];
            2'd2: dig = tk64[L1_BITS + 2 * LV_BITS +: LV_BITS];
            default: dig = tk64[L1_BITS + 3 * LV_BITS +: LV_BITS];
        endcase
    end

    assign cslot = SLOT_W'(L1_SLOTS) + (SLOT_W'(r_k) << LV_BITS) + SLOT_W'(dig);
    assign fslot = SLOT_W'(r_tick[L1_BITS-1:0]);
    assign id_p1 = LINK_W'({1'b0, r_id}) + LINK_W'(1);
    assign tid6  = {1'b0, i_timer_id};
    assign out_free = !r_ov || !i_out_stall;
    assign rem_m1 = r_remain[tidx] - 32'd1;
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;  n_ret = r_ret;  n_after = r_after;
        n_clr = r_clr;      n_pslot = r_pslot;  n_k = r_k;
        n_h = r_h;  n_t = r_t;  n_p = r_p;  n_n = r_n;  n_id = r_id;
        n_tick = r_tick;  n_est = r_est;  n_eid = r_eid;  n_elast = r_elast;
        tidx = r_id;
        arm_we = 1'b0;  exp_we = 1'b0;  rem_we = 1'b0;  prev_we = 1'b0;
        next_we = 1'b0; where_we = 1'b0; used_clr = 1'b0;
        exp_val = r_tick + r_interval[tidx];
        rem_val = rem_m1;
        prev_val = '0;  next_val = '0;
        ram_we = 1'b0;  ram_waddr = r_pslot;  ram_wdata = '0;  ram_raddr = r_pslot;
        emit_go = 1'b0;
        again = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                n_clr     = r_clr + SLOT_W'(1);
                if (r_clr == SLOT_W'(NUM_SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_eid   = '0;
                    n_elast = 1'b1;
                    n_after = S_IDLE;
                    unique case (i_func)
                        FN_ARM: begin
                            if (i_timeout_ms == 32'd0) begin
                                n_est = ST_BAD_TO;  n_state = S_EMIT;
                            end else if (i_repeat_mode == MODE_BAD) begin
                                n_est = ST_BAD_MODE;  n_state = S_EMIT;
                            end else if (!free_any) begin
                                n_est = ST_FULL;  n_state = S_EMIT;
                            end else begin
                                tidx    = free_id;
                                arm_we  = 1'b1;
                                n_id    = free_id;
                                n_est   = ST_ARMED;
                                n_eid   = f_rid(free_id);
                                n_ret   = S_EMIT;
                                n_state = S_PL_RD;
                            end
                        end
                        FN_TICK: begin
                            n_tick  = r_tick + 32'd1;
                            n_state = S_TICK;
                        end
                        FN_CANCEL: begin
                            n_est   = ST_CANCELLED;
                            n_eid   = i_timer_id;
                            n_state = S_EMIT;
                            tidx    = ID_W'(i_timer_id);
                            if (tid6 < 6'(POOL_SIZE) && r_used[tidx]) begin
                                n_id    = tidx;
                                n_state = S_UN_RD;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_TICK: begin
                n_k = 2'd0;
                n_state = (r_tick[L1_BITS-1:0] == '0) ? S_CAS_RD : S_FI_RD;
            end
            S_CAS_RD: begin
                ram_raddr = cslot;
                n_state   = S_CAS_CLR;
            end
            S_CAS_CLR: begin
                n_h       = rd_head;
                ram_we    = 1'b1;
                ram_waddr = cslot;
                n_state   = S_CAS_NEXT;
            end
            S_CAS_NEXT: begin
                if (r_h == '0) begin
                    if (dig != '0 || r_k == 2'd3) begin
                        n_state = S_FI_RD;
                    end else begin
                        n_k     = r_k + 2'd1;
                        n_state = S_CAS_RD;
                    end
                end else begin
                    tidx    = ID_W'(r_h - LINK_W'(1));
                    n_id    = tidx;
                    n_h     = r_next[tidx];
                    n_ret   = S_CAS_NEXT;
                    n_state = S_PL_RD;
                end
            end
            S_FI_RD: begin
                ram_raddr = fslot;
                n_state   = S_FI_CLR;
            end
            S_FI_CLR: begin
                n_h       = rd_head;
                ram_we    = 1'b1;
                ram_waddr = fslot;
                n_state   = S_FI_NEXT;
            end
            S_FI_NEXT: begin
                n_state = S_EMIT;
                if (r_h == '0) begin
                    n_est   = ST_DONE;
                    n_eid   = '0;
                    n_elast = 1'b1;
                    n_after = S_IDLE;
                end else begin
                    tidx    = ID_W'(r_h - LINK_W'(1));
                    n_id    = tidx;
                    n_h     = r_next[tidx];
                    n_est   = ST_EXPIRED;
                    n_eid   = f_rid(tidx);
                    n_elast = 1'b0;
                    n_after = S_FI_UPD;
                end
            end
            S_FI_UPD: begin
                if (r_mode[tidx] == MODE_COUNTED) begin
                    rem_we = 1'b1;
                end
                again = (r_mode[tidx] == MODE_FOREVER)
                     || (r_mode[tidx] == MODE_COUNTED && rem_m1 != 32'd0);
                if (again) begin
                    exp_we  = 1'b1;
                    n_ret   = S_FI_NEXT;
                    n_state = S_PL_RD;
                end else begin
                    prev_we  = 1'b1;
                    next_we  = 1'b1;
                    used_clr = 1'b1;
                    n_state  = S_FI_NEXT;
                end
            end
            S_PL_RD: begin
                n_pslot   = pl_slot;
                ram_raddr = pl_slot;
                n_state   = S_PL_APPLY;
            end
            S_PL_APPLY: begin
                prev_we   = 1'b1;
                prev_val  = rd_tail;
                next_we   = 1'b1;
                where_we  = 1'b1;
                n_t       = rd_tail;
                ram_we    = 1'b1;
                ram_wdata = {(rd_tail == '0) ? id_p1 : rd_head, id_p1};
                n_state   = S_PL_LINK;
            end
            S_PL_LINK: begin
                if (r_t != '0) begin
                    tidx     = ID_W'(r_t - LINK_W'(1));
                    next_we  = 1'b1;
                    next_val = id_p1;
                end
                n_state = r_ret;
            end
            S_UN_RD: begin
                n_p       = r_prev[tidx];
                n_n       = r_next[tidx];
                n_pslot   = r_where[tidx];
                ram_raddr = r_where[tidx];
                n_state   = S_UN_AP;
            end
            S_UN_AP: begin
                ram_we    = 1'b1;
                ram_wdata = {(r_p != '0) ? rd_head : r_n, (r_n != '0) ? rd_tail : r_p};
                prev_we   = 1'b1;
                next_we   = 1'b1;
                used_clr  = 1'b1;
                n_state   = S_UN_P;
            end
            S_UN_P: begin
                if (r_p != '0) begin
                    tidx     = ID_W'(r_p - LINK_W'(1));
                    next_we  = 1'b1;
                    next_val = r_n;
                end
                n_state = S_UN_N;
            end
            S_UN_N: begin
                if (r_n != '0) begin
                    tidx     = ID_W'(r_n - LINK_W'(1));
                    prev_we  = 1'b1;
                    prev_val = r_p;
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    emit_go = 1'b1;
                    n_state = r_after;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ret   <= S_IDLE;
            r_after <= S_IDLE;
            r_clr   <= '0;
            r_k     <= '0;
            r_h     <= '0;
            r_tick  <= '0;
            r_used  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_after <= n_after;
            r_clr   <= n_clr;
            r_k     <= n_k;
            r_h     <= n_h;
            r_tick  <= n_tick;
            if (arm_we) begin
                r_used[tidx] <= 1'b1;
            end else if (used_clr) begin
                r_used[tidx] <= 1'b0;
            end
            if (emit_go) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    // payload and pool registers, no reset
    always_ff @(posedge i_clk) begin
        r_pslot <= n_pslot;
        r_t     <= n_t;
        r_p     <= n_p;
        r_n     <= n_n;
        r_id    <= n_id;
        r_est   <= n_est;
        r_eid   <= n_eid;
        r_elast <= n_elast;
        if (emit_go) begin
            r_ost   <= r_est;
            r_oid   <= r_eid;
            r_olast <= r_elast;
        end
        if (arm_we) begin
            r_mode[tidx]     <= i_repeat_mode;
            r_interval[tidx] <= i_timeout_ms;
            r_remain[tidx]   <= i_repeat_count;
            r_expiry[tidx]   <= r_tick + i_timeout_ms;
        end
        if (exp_we) begin
            r_expiry[tidx] <= exp_val;
        end
        if (rem_we) begin
            r_remain[tidx] <= rem_val;
        end
        if (prev_we) begin
            r_prev[tidx] <= prev_val;
        end
        if (next_we) begin
            r_next[tidx] <= next_val;
        end
        if (where_we) begin
            r_where[tidx] <= r_pslot;
        end
    end

    assign o_out_valid    = r_ov;
    assign o_status       = r_ost;
    assign o_result_timer = r_oid;
    assign o_last         = r_olast;

endmodule

[src/htw_slot_ram.sv]
// slot head and tail memory of the timer wheel
// one write port, one read port with registered read data
module htw_slot_ram #(
    parameter int DEPTH = 512,
    parameter int AW    = 9,
    parameter int DW    = 12
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

[src/htw_place.sv]
// slot selection for placing a timer on the wheel
// uses htw_pkg sizes
module htw_place (
    input  logic [31:0]                 i_expiry,
    input  logic [31:0]                 i_tick,
    output logic [htw_pkg::SLOT_W-1:0]  o_slot
);
    import htw_pkg::*;

    logic [31:0] d;
    logic [63:0] d64;
    logic [63:0] e64;
    logic [63:0] lim;
    logic [63:0] ee;
    logic        found;

    assign d   = i_expiry - i_tick;
    assign d64 = {32'b0, d};
    assign e64 = {32'b0, i_expiry};

    always_comb begin
        o_slot = SLOT_W'(e64[L1_BITS-1:0]);
        found  = 1'b0;
        lim    = '0;
        ee     = e64;
        if (d64 >= (64'd1 << L1_BITS)) begin
            for (int k = 0; k < 4; k++) begin
                lim = 64'd1 << (L1_BITS + k * LV_BITS + LV_BITS);
                if (!found && (d64 < lim || k == 3)) begin
                    found = 1'b1;
                    // too far for the wheel: park at the farthest slot
                    ee = (d64 >= lim) ? {32'b0, i_tick + lim[31:0] - 32'd1} : e64;
                    o_slot = SLOT_W'(L1_SLOTS + k * LV_SLOTS)
                           + SLOT_W'((ee >> (L1_BITS + k * LV_BITS)) & 64'(LV_SLOTS - 1));
                end
            end
        end
    end

endmodule
